@@ rtl/core/tccs_pkg.sv @@
// shared constants, codes and types of the text console cursor and scroll engine
package tccs_pkg;

	// default geometry of the console
	localparam int DEF_WIDTH       = 80;
	localparam int DEF_HEIGHT      = 25;
	localparam int DEF_LINES       = 204;
	localparam int DEF_TAB_STOP    = 8;
	localparam int DEF_QUEUE_DEPTH = 4;

	// field widths
	localparam int OP_W      = 2;
	localparam int CHAR_W    = 8;
	localparam int ATTR_W    = 8;
	localparam int COL_W     = 7;
	localparam int ROW_W     = 8;
	localparam int LOC_W     = 14;
	localparam int POS_W     = 16;
	localparam int CFG_IDX_W = 1;

	// item operation codes
	localparam logic [OP_W-1:0] OP_PUT  = 2'd0;
	localparam logic [OP_W-1:0] OP_SET  = 2'd1;
	localparam logic [OP_W-1:0] OP_READ = 2'd2;

	// control characters
	localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NL  = 8'd10;

	// blank cell after reset
	localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
	localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h1f;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTRIBUTE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CURSOR_SHOWN   = 1'd1;

	// classified item kinds
	typedef enum logic [2:0] {
		K_CHAR,
		K_TAB,
		K_NL,
		K_SET,
		K_READ,
		K_NOP
	} kind_t;

	// command handed from the front to the back
	typedef struct packed {
		kind_t             kind;
		logic [CHAR_W-1:0] ch;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [POS_W-1:0]  rd_addr;
		logic              rd_ok;
	} cmd_t;

endpackage

@@ rtl/core/tccs_if.sv @@
// item and result channel interfaces of the text console engine
interface tccs_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [tccs_pkg::OP_W-1:0]     op;
	logic [tccs_pkg::CHAR_W-1:0]   char_code;
	logic [tccs_pkg::COL_W-1:0]    col;
	logic [tccs_pkg::ROW_W-1:0]    row;

	modport source (output valid, output op, output char_code, output col, output row,
		input ready);
	modport sink (input valid, input op, input char_code, input col, input row,
		output ready);
endinterface

interface tccs_result_if;
	logic                          valid;
	logic                          ready;
	logic [tccs_pkg::CHAR_W-1:0]   cell_char;
	logic [tccs_pkg::ATTR_W-1:0]   cell_attr;
	logic [tccs_pkg::LOC_W-1:0]    cursor_location;
	logic [tccs_pkg::LOC_W-1:0]    start_location;

	modport source (output valid, output cell_char, output cell_attr,
		output cursor_location, output start_location, input ready);
	modport sink (input valid, input cell_char, input cell_attr,
		input cursor_location, input start_location, output ready);
endinterface

@@ rtl/core/text_console_cursor_scroll.sv @@
// top level of the text console cursor and scroll engine
//
// Items arrive on the cmd channel (op, char_code, col, row) and each one gives
// exactly one result on the result channel (cell_char, cell_attr,
// cursor_location, start_location), in order. Both channels transfer on a
// rising edge with valid and ready high. Registers are to be written through
// cfg_we, cfg_index and cfg_data only while no item is in flight; the block
// itself does not enforce this. The front classifies each item into a queue
// of QUEUE_DEPTH commands; the back runs each command in ST_RUN, for the cell
// store access and cursor update, then in ST_FINISH, to load the result
// register, and takes no new command until that load is done. A put that
// scrolls past the last screen copies the HEIGHT-1 remaining rows to the top
// through the single store read and write port, one cell a cycle, in ST_COPY.
// After reset the store is cleared to blank cells one cell a cycle, with
// cmd.ready low; register writes are taken during that time. When the
// receiver stalls, the result register holds and the queue keeps filling
// until it is full.
module text_console_cursor_scroll #(
	parameter int WIDTH       = tccs_pkg::DEF_WIDTH,
	parameter int HEIGHT      = tccs_pkg::DEF_HEIGHT,
	parameter int LINES       = tccs_pkg::DEF_LINES,
	parameter int TAB_STOP    = tccs_pkg::DEF_TAB_STOP,
	parameter int QUEUE_DEPTH = tccs_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tccs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tccs_pkg::ATTR_W-1:0]      cfg_data,
	tccs_cmd_if.sink                         cmd,
	tccs_result_if.source                    result
);

	logic            clearing;
	logic            push_valid;
	logic            push_ready;
	tccs_pkg::cmd_t  push_data;
	logic            pop_valid;
	logic            pop_ready;
	tccs_pkg::cmd_t  pop_data;

	// item classification
	tccs_front #(
		.WIDTH (WIDTH),
		.LINES (LINES)
	) u_front (
		.cmd        (cmd),
		.clearing   (clearing),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// command queue
	tccs_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// execution and results
	tccs_back #(
		.WIDTH    (WIDTH),
		.HEIGHT   (HEIGHT),
		.LINES    (LINES),
		.TAB_STOP (TAB_STOP)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (pop_valid),
		.q_ready   (pop_ready),
		.q_data    (pop_data),
		.clearing  (clearing),
		.result    (result)
	);

endmodule

@@ rtl/core/tccs_front.sv @@
// front end: takes items, classifies them and forms queue commands
module tccs_front #(
	parameter int WIDTH = tccs_pkg::DEF_WIDTH,
	parameter int LINES = tccs_pkg::DEF_LINES
) (
	tccs_cmd_if.sink        cmd,
	input  logic            clearing,
	output logic            push_valid,
	input  logic            push_ready,
	output tccs_pkg::cmd_t  push_data
);

	// no transfer while the store is being cleared
	assign cmd.ready  = push_ready && !clearing;
	assign push_valid = cmd.valid && !clearing;

	// classify the item and precompute set and read operands
	always_comb begin
		push_data.kind    = tccs_pkg::K_NOP;
		push_data.ch      = cmd.char_code;
		push_data.col     = cmd.col;
		push_data.row     = cmd.row;
		push_data.rd_addr = tccs_pkg::POS_W'(cmd.row) * tccs_pkg::POS_W'(WIDTH)
			+ tccs_pkg::POS_W'(cmd.col);
		push_data.rd_ok   = ({1'b0, cmd.col} < (tccs_pkg::COL_W + 1)'(WIDTH))
			&& ({1'b0, cmd.row} < (tccs_pkg::ROW_W + 1)'(LINES));
		case (cmd.op)
			tccs_pkg::OP_PUT: begin
				if (cmd.char_code == tccs_pkg::CH_TAB) begin
					push_data.kind = tccs_pkg::K_TAB;
				end else if (cmd.char_code == tccs_pkg::CH_NL) begin
					push_data.kind = tccs_pkg::K_NL;
				end else begin
					push_data.kind = tccs_pkg::K_CHAR;
				end
			end
			tccs_pkg::OP_SET: begin
				push_data.kind = tccs_pkg::K_SET;
				if (cmd.col > tccs_pkg::COL_W'(WIDTH - 1)) begin
					push_data.col = tccs_pkg::COL_W'(WIDTH - 1);
				end
				if (cmd.row > tccs_pkg::ROW_W'(LINES - 1)) begin
					push_data.row = tccs_pkg::ROW_W'(LINES - 1);
				end
			end
			tccs_pkg::OP_READ: begin
				push_data.kind = tccs_pkg::K_READ;
			end
			default: begin
				push_data.kind = tccs_pkg::K_NOP;
			end
		endcase
	end

endmodule

@@ rtl/core/tccs_fifo.sv @@
// short command queue between the front and the back
module tccs_fifo #(
	parameter int DEPTH = tccs_pkg::DEF_QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  tccs_pkg::cmd_t  push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output tccs_pkg::cmd_t  pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tccs_pkg::cmd_t   slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ rtl/core/tccs_back.sv @@
// back end: cell store, cursor and scroll state, wrap copy and result register
module tccs_back #(
	parameter int WIDTH    = tccs_pkg::DEF_WIDTH,
	parameter int HEIGHT   = tccs_pkg::DEF_HEIGHT,
	parameter int LINES    = tccs_pkg::DEF_LINES,
	parameter int TAB_STOP = tccs_pkg::DEF_TAB_STOP
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tccs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tccs_pkg::ATTR_W-1:0]      cfg_data,
	input  logic                             q_valid,
	output logic                             q_ready,
	input  tccs_pkg::cmd_t                   q_data,
	output logic                             clearing,
	tccs_result_if.source                    result
);

	localparam int CELLS     = LINES * WIDTH;
	localparam int MEM_AW    = $clog2(CELLS);
	localparam int LAST_TOP  = (LINES > HEIGHT) ? LINES - HEIGHT : 0;
	localparam int ROW_WRAP  = (HEIGHT - 1 < LINES - 1) ? HEIGHT - 1 : LINES - 1;
	localparam int CPR_W     = $clog2(HEIGHT);
	localparam int COL_W     = tccs_pkg::COL_W;
	localparam int ROW_W     = tccs_pkg::ROW_W;
	localparam int POS_W     = tccs_pkg::POS_W;
	localparam int LOC_W     = tccs_pkg::LOC_W;
	localparam int TAB_N     = 2 ** COL_W;
	localparam int TAB_ENT_W = COL_W + 2;

	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_RUN    = 2'd1;
	localparam logic [1:0] ST_COPY   = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	// next tab column per column, already wrapped, with the row advance on top
	function automatic logic [TAB_N*TAB_ENT_W-1:0] tab_table();
		logic [TAB_N*TAB_ENT_W-1:0] t;
		int ph;
		int v;
		int adv;
		t  = '0;
		ph = 0;
		for (int i = 0; i < TAB_N; i++) begin
			v   = i + TAB_STOP - ph;
			adv = 0;
			for (int k = 0; k < 2; k++) begin
				if (v >= WIDTH) begin
					v   = v - WIDTH;
					adv = adv + 1;
				end
			end
			t[i*TAB_ENT_W +: TAB_ENT_W] = {2'(adv), COL_W'(v)};
			ph = (ph == TAB_STOP - 1) ? 0 : ph + 1;
		end
		return t;
	endfunction

	localparam logic [TAB_N*TAB_ENT_W-1:0] TAB_TBL = tab_table();

	logic [1:0]             state_q;
	logic [MEM_AW-1:0]      clr_addr_q;
	logic [COL_W-1:0]       col_q;
	logic [ROW_W-1:0]       row_q;
	logic [ROW_W-1:0]       top_q;
	logic [POS_W-1:0]       start_q;
	logic [LOC_W-1:0]       latch_q;
	logic [tccs_pkg::ATTR_W-1:0] attr_q;
	logic                   shown_q;
	tccs_pkg::kind_t        kind_q;
	logic                   rd_ok_q;

	logic [MEM_AW-1:0]      cp_src_q;
	logic [MEM_AW-1:0]      cp_dst_q;
	logic [COL_W-1:0]       cp_col_q;
	logic [CPR_W-1:0]       cp_rows_q;
	logic                   cp_issue_q;
	logic                   cp_wr_s1;
	logic [MEM_AW-1:0]      cp_dst_s1;

	logic [15:0]            mem [CELLS];
	logic [15:0]            rd_data_q;
	logic                   mem_we;
	logic [MEM_AW-1:0]      mem_wa;
	logic [15:0]            mem_wd;
	logic                   mem_re;
	logic [MEM_AW-1:0]      mem_ra;

	logic                   out_valid_q;
	logic [tccs_pkg::CHAR_W-1:0] out_char_q;
	logic [tccs_pkg::ATTR_W-1:0] out_attr_q;
	logic [LOC_W-1:0]       out_cursor_q;
	logic [LOC_W-1:0]       out_start_q;

	tccs_pkg::cmd_t         head;
	logic                   run_go;
	logic                   fin_go;
	logic [POS_W-1:0]       cur_pos;
	logic [TAB_ENT_W-1:0]   tab_ent;
	logic [1:0]             adv;
	logic [COL_W-1:0]       ncol;
	logic [ROW_W:0]         nrow;
	logic                   scroll;
	logic                   do_copy;
	logic [ROW_W-1:0]       rows_avail;
	logic [CPR_W-1:0]       copy_rows;
	logic [ROW_W-1:0]       row_put;
	logic                   moves_cursor;
	logic [LOC_W-1:0]       new_latch;

	assign head     = q_data;
	assign clearing = state_q == ST_CLEAR;
	assign q_ready  = state_q == ST_RUN;
	assign run_go   = q_valid && (state_q == ST_RUN);
	assign fin_go   = (state_q == ST_FINISH) && (!out_valid_q || result.ready);

	// cursor cell offset, shared by the put write and the location latch
	assign cur_pos = POS_W'(row_q) * POS_W'(WIDTH) + POS_W'(col_q);
	assign tab_ent = TAB_TBL[col_q * TAB_ENT_W +: TAB_ENT_W];

	// cursor advance, wrap and scroll decision for put items
	always_comb begin
		adv  = '0;
		ncol = col_q;
		case (head.kind)
			tccs_pkg::K_CHAR: begin
				if (col_q == COL_W'(WIDTH - 1)) begin
					ncol = '0;
					adv  = 2'd1;
				end else begin
					ncol = col_q + 1'b1;
				end
			end
			tccs_pkg::K_TAB: begin
				{adv, ncol} = tab_ent;
			end
			tccs_pkg::K_NL: begin
				ncol = '0;
				adv  = 2'd1;
			end
			default: begin
				adv  = '0;
				ncol = col_q;
			end
		endcase
		nrow       = {1'b0, row_q} + (ROW_W + 1)'(adv);
		scroll     = (adv != '0) && (nrow >= (ROW_W + 1)'(top_q) + (ROW_W + 1)'(HEIGHT));
		do_copy    = scroll && (top_q >= ROW_W'(LAST_TOP));
		rows_avail = ROW_W'(LINES - 1) - top_q;
		copy_rows  = (rows_avail < ROW_W'(HEIGHT - 1)) ? CPR_W'(rows_avail)
			: CPR_W'(HEIGHT - 1);
		if (do_copy) begin
			row_put = ROW_W'(ROW_WRAP);
		end else if (nrow > (ROW_W + 1)'(LINES - 1)) begin
			row_put = ROW_W'(LINES - 1);
		end else begin
			row_put = nrow[ROW_W-1:0];
		end
	end

	// location latch after the item
	always_comb begin
		moves_cursor = kind_q inside {tccs_pkg::K_CHAR, tccs_pkg::K_TAB, tccs_pkg::K_NL,
			tccs_pkg::K_SET};
		new_latch = (shown_q && moves_cursor) ? cur_pos[LOC_W-1:0] : latch_q;
	end

	// memory port selection
	always_comb begin
		mem_we = 1'b0;
		mem_wa = cur_pos[MEM_AW-1:0];
		mem_wd = {attr_q, head.ch};
		mem_re = 1'b0;
		mem_ra = head.rd_addr[MEM_AW-1:0];
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_addr_q;
				mem_wd = {tccs_pkg::RESET_ATTR, tccs_pkg::BLANK_CHAR};
			end
			ST_RUN: begin
				mem_we = run_go && (head.kind == tccs_pkg::K_CHAR);
				mem_re = run_go && (head.kind == tccs_pkg::K_READ) && head.rd_ok;
			end
			ST_COPY: begin
				mem_we = cp_wr_s1;
				mem_wa = cp_dst_s1;
				mem_wd = rd_data_q;
				mem_re = cp_issue_q;
				mem_ra = cp_src_q;
			end
			default: begin
				mem_we = 1'b0;
				mem_re = 1'b0;
			end
		endcase
	end

	// cell store with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_ra];
		end
	end

	// control state, cursor state and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			col_q       <= '0;
			row_q       <= '0;
			top_q       <= '0;
			start_q     <= '0;
			latch_q     <= '0;
			attr_q      <= tccs_pkg::RESET_ATTR;
			shown_q     <= 1'b1;
			cp_issue_q  <= 1'b0;
			cp_wr_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tccs_pkg::REG_TEXT_ATTRIBUTE: attr_q  <= cfg_data;
					tccs_pkg::REG_CURSOR_SHOWN:   shown_q <= cfg_data[0];
					default: ;
				endcase
			end

			if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			cp_wr_s1 <= 1'b0;

			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == MEM_AW'(CELLS - 1)) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (run_go) begin
						state_q <= ST_FINISH;
						if (head.kind == tccs_pkg::K_SET) begin
							col_q <= head.col;
							row_q <= head.row;
						end else if (head.kind == tccs_pkg::K_CHAR
							|| head.kind == tccs_pkg::K_TAB
							|| head.kind == tccs_pkg::K_NL) begin
							col_q <= ncol;
							row_q <= row_put;
							if (do_copy) begin
								top_q   <= '0;
								start_q <= '0;
								if (copy_rows != '0) begin
									state_q    <= ST_COPY;
									cp_issue_q <= 1'b1;
								end
							end else if (scroll) begin
								top_q   <= top_q + 1'b1;
								start_q <= start_q + POS_W'(WIDTH);
							end
						end
					end
				end
				ST_COPY: begin
					cp_wr_s1 <= cp_issue_q;
					if (cp_issue_q && cp_col_q == COL_W'(WIDTH - 1)
						&& cp_rows_q == CPR_W'(1)) begin
						cp_issue_q <= 1'b0;
					end
					if (!cp_issue_q) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (fin_go) begin
						latch_q     <= new_latch;
						out_valid_q <= 1'b1;
						state_q     <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	// item, copy and result payload registers
	always_ff @(posedge clk) begin
		if (run_go) begin
			kind_q  <= head.kind;
			rd_ok_q <= head.rd_ok;
			cp_src_q  <= MEM_AW'(start_q + POS_W'(WIDTH));
			cp_dst_q  <= '0;
			cp_col_q  <= '0;
			cp_rows_q <= copy_rows;
		end
		if (state_q == ST_COPY) begin
			cp_dst_s1 <= cp_dst_q;
			if (cp_issue_q) begin
				cp_src_q <= cp_src_q + 1'b1;
				cp_dst_q <= cp_dst_q + 1'b1;
				if (cp_col_q == COL_W'(WIDTH - 1)) begin
					cp_col_q  <= '0;
					cp_rows_q <= cp_rows_q - 1'b1;
				end else begin
					cp_col_q <= cp_col_q + 1'b1;
				end
			end
		end
		if (fin_go) begin
			if (kind_q == tccs_pkg::K_READ && rd_ok_q) begin
				out_char_q <= rd_data_q[7:0];
				out_attr_q <= rd_data_q[15:8];
			end else begin
				out_char_q <= '0;
				out_attr_q <= '0;
			end
			out_cursor_q <= new_latch;
			out_start_q  <= start_q[LOC_W-1:0];
		end
	end

	// result channel
	assign result.valid           = out_valid_q;
	assign result.cell_char       = out_char_q;
	assign result.cell_attr       = out_attr_q;
	assign result.cursor_location = out_cursor_q;
	assign result.start_location  = out_start_q;

endmodule

@@ rtl/core/tccs_checker.sv @@
// port checker of the text console engine and its binding to the top level
module tccs_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cmd_valid,
	input logic                             cmd_ready,
	input logic                             res_valid,
	input logic                             res_ready,
	input logic [tccs_pkg::CHAR_W-1:0]      cell_char,
	input logic [tccs_pkg::ATTR_W-1:0]      cell_attr,
	input logic [tccs_pkg::LOC_W-1:0]       cursor_location,
	input logic [tccs_pkg::LOC_W-1:0]       start_location
);

	logic [7:0] pend_q;
	logic       cmd_xfer;
	logic       res_xfer;

	assign cmd_xfer = cmd_valid && cmd_ready;
	assign res_xfer = res_valid && res_ready;

	// items taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (cmd_xfer && !res_xfer) begin
			pend_q <= pend_q + 1'b1;
		end else if (res_xfer && !cmd_xfer) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	// a stalled result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=>
		$stable({cell_char, cell_attr, cursor_location, start_location}))
		else $error("result payload changed while stalled");

	// no result without an item taken before it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pend_q != '0)
		else $error("result offered with no item outstanding");

	// store clear keeps items out right after reset
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !cmd_ready)
		else $error("item taken during store clear");

endmodule

bind text_console_cursor_scroll tccs_checker u_tccs_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cmd_valid       (cmd.valid),
	.cmd_ready       (cmd.ready),
	.res_valid       (result.valid),
	.res_ready       (result.ready),
	.cell_char       (result.cell_char),
	.cell_attr       (result.cell_attr),
	.cursor_location (result.cursor_location),
	.start_location  (result.start_location)
);
